/* src/clex_pkg.sv */
// Shared types and constants for the load/exchange executor.
// Depends on nothing; used by the top level.
package clex_pkg;
	localparam logic [1:0] KIND_EXEC = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_SETPC = 2'd2;

	localparam logic [2:0] ST_EXEC = 3'd0;
	localparam logic [2:0] ST_UNSUP = 3'd1;
	localparam logic [2:0] ST_HALT = 3'd2;
	localparam logic [2:0] ST_IGNORED = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [7:0] PFX_BITS = 8'hCB;
	localparam logic [7:0] PFX_IX = 8'hDD;
	localparam logic [7:0] PFX_EXT = 8'hED;
	localparam logic [7:0] PFX_IY = 8'hFD;
	localparam logic [7:0] OP_HALT = 8'h76;
	localparam logic [7:0] OP_EXDEHL = 8'hEB;
	localparam logic [7:0] OP_EXSPHL = 8'hE3;
	localparam logic [7:0] OP_EXAF = 8'h08;
	localparam logic [7:0] OP_LDSPHL = 8'hF9;
	localparam logic [7:0] BYTE_MASK = 8'hFF;
	localparam logic [7:0] OP_NOP = 8'h00;
	localparam logic [7:0] OP_LDABC = 8'h0A;
	localparam logic [7:0] OP_LDADE = 8'h1A;
	localparam logic [7:0] OP_LDBCA = 8'h02;
	localparam logic [7:0] OP_LDDEA = 8'h12;
	localparam logic [7:0] OP_LDANN = 8'h3A;
	localparam logic [7:0] OP_LDNNA = 8'h32;
	localparam logic [7:0] OP_LDNNHL = 8'h22;
	localparam logic [7:0] OP_LDHLNN = 8'h2A;
	localparam logic [7:0] OP_PUSHBC = 8'hC5;
	localparam logic [7:0] OP_PUSHDE = 8'hD5;
	localparam logic [7:0] OP_PUSHHL = 8'hE5;
	localparam logic [7:0] OP_PUSHAF = 8'hF5;
	localparam logic [7:0] OP_POPBC = 8'hC1;
	localparam logic [7:0] OP_POPDE = 8'hD1;
	localparam logic [7:0] OP_POPHL = 8'hE1;
	localparam logic [7:0] OP_POPAF = 8'hF1;

	// Memory micro-op class of an instruction
	typedef enum logic [3:0] {
		CL_NONE, CL_UNSUP, CL_PFX, CL_HALT, CL_LDRR, CL_LDRHL, CL_LDHLR, CL_IMM,
		CL_RDA, CL_WRA, CL_NNRD, CL_NNWR, CL_WRD, CL_PUSH, CL_POP, CL_EXSP
	} cls_t;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_CLEAR  = 11'b00000000010,
		S_FETCH  = 11'b00000000100,
		S_DECODE = 11'b00000001000,
		S_OPLO   = 11'b00000010000,
		S_OPHI   = 11'b00000100000,
		S_RD1    = 11'b00001000000,
		S_RD2    = 11'b00010000000,
		S_WR1    = 11'b00100000000,
		S_WR2    = 11'b01000000000,
		S_DONE   = 11'b10000000000
	} state_t;
endpackage

/* src/clex_ram.sv */
// Generic single-port RAM with registered read.
// Depends on nothing.
module clex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* src/cpu_load_exchange_executor_top.sv */
// Load/exchange subset CPU core with its own byte memory.
// Byte write, PC set and halted items finish without leaving idle; an executed
// instruction passes through fetch, decode, its accesses of the single memory port and finish.
// Throughput: one item at a time; the next item is taken the cycle after the result transfers.
// Reset: registers clear, core running; a clearing pass then zeroes memory
// while in_ready stays low.
module cpu_load_exchange_executor_top import clex_pkg::*; #(
	parameter int MEM_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  executed_opcode,
	output logic [7:0]  acc_value,
	output logic [7:0]  flag_value,
	output logic [15:0] pair_bc,
	output logic [15:0] pair_de,
	output logic [15:0] pair_hl,
	output logic [15:0] stack_ptr,
	output logic [15:0] prog_counter
);
	localparam int AW = $clog2(MEM_DEPTH);

	state_t state_q;
	cls_t   cls_q;
	logic [7:0]  a_q, f_q, a2_q, f2_q, op_q, tmp_q;
	logic [15:0] bc_q, de_q, hl_q, sp_q, pc_q, ea_q, wv_q;
	logic        run_q;
	logic [AW-1:0] clr_q;
	logic [2:0]  st_q;
	logic        ob_q;

	logic          we;
	logic [AW-1:0] ma;
	logic [7:0]    wd, rd;
	logic [15:0]   maddr;

	clex_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
		.clk(clk), .we(we), .addr(ma), .wdata(wd), .rdata(rd)
	);

	function automatic logic [7:0] rsel(input logic [2:0] i, input logic [15:0] bc,
		input logic [15:0] de, input logic [15:0] hl, input logic [7:0] a);
		case (i)
			3'd0: rsel = bc[15:8];
			3'd1: rsel = bc[7:0];
			3'd2: rsel = de[15:8];
			3'd3: rsel = de[7:0];
			3'd4: rsel = hl[15:8];
			3'd5: rsel = hl[7:0];
			default: rsel = a;
		endcase
	endfunction

	function automatic cls_t classify(input logic [7:0] op);
		cls_t c;
		c = CL_UNSUP;
		if (op == PFX_BITS || op == PFX_IX || op == PFX_EXT || op == PFX_IY) c = CL_PFX;
		else if (op == OP_HALT) c = CL_HALT;
		else if (op[7:6] == 2'b01) begin
			if (op[2:0] == 3'd6) c = CL_LDRHL;
			else if (op[5:3] == 3'd6) c = CL_LDHLR;
			else c = CL_LDRR;
		end else if ((op & 8'hC7) == 8'h06) c = CL_IMM;
		else begin
			case (op)
				OP_NOP, OP_LDSPHL, OP_EXDEHL, OP_EXAF: c = CL_NONE;
				OP_LDABC, OP_LDADE: c = CL_RDA;
				OP_LDBCA, OP_LDDEA: c = CL_WRA;
				OP_LDANN, OP_LDHLNN: c = CL_NNRD;
				OP_LDNNA, OP_LDNNHL: c = CL_NNWR;
				OP_PUSHBC, OP_PUSHDE, OP_PUSHHL, OP_PUSHAF: c = CL_PUSH;
				OP_POPBC, OP_POPDE, OP_POPHL, OP_POPAF: c = CL_POP;
				OP_EXSPHL: c = CL_EXSP;
				default: c = CL_UNSUP;
			endcase
		end
		classify = c;
	endfunction

	// Memory port address and write control
	always_comb begin
		we = 1'b0;
		wd = wv_q[7:0];
		maddr = pc_q;
		case (state_q)
			S_IDLE: begin
				maddr = address;
				wd = data;
				we = in_valid && !ob_q && opcode == KIND_WRITE;
			end
			S_FETCH, S_OPLO, S_OPHI: maddr = pc_q;
			S_RD1, S_WR1: maddr = ea_q;
			S_RD2: maddr = ea_q + 16'd1;
			S_WR2: begin
				maddr = ea_q + 16'd1;
				wd = wv_q[15:8];
			end
			default: maddr = pc_q;
		endcase
		// POP and LD HL,(nn) pass through WR2 only to capture the high byte
		if (state_q == S_WR1 ||
			(state_q == S_WR2 && cls_q != CL_POP && cls_q != CL_NNRD)) we = 1'b1;
		ma = maddr[AW-1:0];
		if (state_q == S_CLEAR) begin
			ma = clr_q;
			wd = 8'd0;
			we = 1'b1;
		end
	end

	assign in_ready = (state_q == S_IDLE) && !ob_q;
	assign out_valid = ob_q;
	assign status = st_q;
	assign executed_opcode = op_q;
	assign acc_value = a_q;
	assign flag_value = f_q;
	assign pair_bc = bc_q;
	assign pair_de = de_q;
	assign pair_hl = hl_q;
	assign stack_ptr = sp_q;
	assign prog_counter = pc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			a_q <= '0; f_q <= '0; a2_q <= '0; f2_q <= '0;
			bc_q <= '0; de_q <= '0; hl_q <= '0; sp_q <= '0; pc_q <= '0;
			run_q <= 1'b1;
			ob_q <= 1'b0;
			st_q <= ST_EXEC;
			op_q <= '0;
			cls_q <= CL_NONE;
			tmp_q <= '0; ea_q <= '0; wv_q <= '0;
		end else begin
			if (ob_q && out_ready) ob_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MEM_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid && !ob_q) begin
						op_q <= '0;
						case (opcode)
							KIND_EXEC: begin
								if (run_q) state_q <= S_FETCH;
								else begin
									st_q <= ST_IGNORED;
									ob_q <= 1'b1;
								end
							end
							KIND_WRITE: begin
								st_q <= ST_DONE;
								ob_q <= 1'b1;
							end
							KIND_SETPC: begin
								pc_q <= address;
								run_q <= 1'b1;
								st_q <= ST_DONE;
								ob_q <= 1'b1;
							end
							default: begin
								st_q <= ST_UNSUP;
								ob_q <= 1'b1;
							end
						endcase
					end
				end
				S_FETCH: begin
					pc_q <= pc_q + 16'd1;
					state_q <= S_DECODE;
				end
				S_DECODE: begin
					op_q <= rd;
					cls_q <= classify(rd);
					st_q <= ST_EXEC;
					state_q <= S_DONE;
					case (classify(rd))
						CL_UNSUP: st_q <= ST_UNSUP;
						CL_PFX: begin
							st_q <= ST_UNSUP;
							state_q <= S_OPLO;
						end
						CL_HALT: begin
							run_q <= 1'b0;
							st_q <= ST_HALT;
						end
						CL_LDRR: tmp_q <= rsel(rd[2:0], bc_q, de_q, hl_q, a_q);
						CL_LDRHL: begin
							ea_q <= hl_q;
							state_q <= S_RD1;
						end
						CL_LDHLR: begin
							ea_q <= hl_q;
							wv_q <= {8'd0, rsel(rd[2:0], bc_q, de_q, hl_q, a_q)};
							state_q <= S_WR1;
						end
						CL_IMM, CL_NNRD, CL_NNWR: state_q <= S_OPLO;
						CL_RDA: begin
							ea_q <= rd[4] ? de_q : bc_q;
							state_q <= S_RD1;
						end
						CL_WRA: begin
							ea_q <= rd[4] ? de_q : bc_q;
							wv_q <= {8'd0, a_q};
							state_q <= S_WR1;
						end
						CL_PUSH: begin
							ea_q <= sp_q - 16'd2;
							sp_q <= sp_q - 16'd2;
							case (rd[5:4])
								2'd0: wv_q <= bc_q;
								2'd1: wv_q <= de_q;
								2'd2: wv_q <= hl_q;
								default: wv_q <= {a_q, f_q};
							endcase
							state_q <= S_WR1;
						end
						CL_POP: begin
							ea_q <= sp_q;
							sp_q <= sp_q + 16'd2;
							state_q <= S_RD1;
						end
						CL_EXSP: begin
							ea_q <= sp_q;
							wv_q <= hl_q;
							state_q <= S_RD1;
						end
						default: ;
					endcase
				end
				S_OPLO: begin
					pc_q <= pc_q + 16'd1;
					if (cls_q == CL_PFX) state_q <= S_DONE;
					else if (cls_q == CL_IMM) state_q <= S_OPHI;
					else state_q <= S_OPHI;
				end
				S_OPHI: begin
					// rd holds the low operand byte here
					if (cls_q == CL_IMM) begin
						if (op_q[5:3] == 3'd6) begin
							ea_q <= hl_q;
							wv_q <= {8'd0, rd};
							state_q <= S_WR1;
						end else begin
							tmp_q <= rd;
							state_q <= S_DONE;
						end
					end else begin
						ea_q[7:0] <= rd;
						pc_q <= pc_q + 16'd1;
						state_q <= S_RD1;
						// high byte arrives next cycle; RD1 waits on it
						cls_q <= cls_q;
						tmp_q <= 8'hFF;
					end
				end
				S_RD1: begin
					if ((cls_q == CL_NNRD || cls_q == CL_NNWR) && tmp_q == 8'hFF) begin
						// capture high operand byte, then start the real access
						ea_q[15:8] <= rd;
						tmp_q <= 8'h00;
						if (cls_q == CL_NNWR) begin
							wv_q <= (op_q == OP_LDNNA) ? {8'd0, a_q} : hl_q;
							state_q <= S_WR1;
						end
					end else begin
						state_q <= S_RD2;
					end
				end
				S_RD2: begin
					// rd is the byte at ea
					if (cls_q == CL_LDRHL || cls_q == CL_RDA ||
						(cls_q == CL_NNRD && op_q == OP_LDANN)) begin
						tmp_q <= rd;
						state_q <= S_DONE;
					end else if (tmp_q == 8'h00 || cls_q == CL_POP || cls_q == CL_EXSP
						|| cls_q == CL_NNRD) begin
						ea_q <= ea_q;
						tmp_q <= rd;
						state_q <= S_WR2;
					end
				end
				S_WR1: begin
					if (cls_q == CL_NNWR && op_q == OP_LDNNA) state_q <= S_DONE;
					else if (cls_q == CL_LDHLR || cls_q == CL_WRA || cls_q == CL_IMM
						|| cls_q == CL_EXSP)
						state_q <= S_DONE;
					else state_q <= S_WR2;
				end
				S_WR2: begin
					// capture the high byte read at ea+1; EX (SP),HL then writes the low byte
					if (cls_q == CL_POP || cls_q == CL_NNRD) begin
						wv_q <= {rd, tmp_q};
						state_q <= S_DONE;
					end else if (cls_q == CL_EXSP) begin
						hl_q <= {rd, tmp_q};
						state_q <= S_WR1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					case (cls_q)
						CL_LDRR, CL_LDRHL, CL_IMM: begin
							case (op_q[5:3])
								3'd0: bc_q[15:8] <= tmp_q;
								3'd1: bc_q[7:0] <= tmp_q;
								3'd2: de_q[15:8] <= tmp_q;
								3'd3: de_q[7:0] <= tmp_q;
								3'd4: hl_q[15:8] <= tmp_q;
								3'd5: hl_q[7:0] <= tmp_q;
								3'd7: a_q <= tmp_q;
								default: ;
							endcase
						end
						CL_RDA: a_q <= tmp_q;
						CL_NNRD: begin
							if (op_q == OP_LDANN) a_q <= tmp_q;
							else hl_q <= wv_q;
						end
						CL_POP: begin
							case (op_q[5:4])
								2'd0: bc_q <= wv_q;
								2'd1: de_q <= wv_q;
								2'd2: hl_q <= wv_q;
								default: begin
									a_q <= wv_q[15:8];
									f_q <= wv_q[7:0];
								end
							endcase
						end
						CL_NONE: begin
							if (op_q == OP_LDSPHL) sp_q <= hl_q;
							else if (op_q == OP_EXDEHL) begin
								de_q <= hl_q;
								hl_q <= de_q;
							end else if (op_q == OP_EXAF) begin
								a_q <= a2_q; a2_q <= a_q;
								f_q <= f2_q; f2_q <= f_q;
							end
						end
						default: ;
					endcase
					ob_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
